// File: hw/rtl/servo_channel_frame_decoder_unit_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef SERVO_CHANNEL_FRAME_DECODER_UNIT_MACROS_SVH
`define SERVO_CHANNEL_FRAME_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfd: next-cycle check failed");

`endif

// File: hw/rtl/scfd_pkg.sv
package scfd_pkg;

    localparam int MAX_CHANNELS = 12;
    localparam logic [3:0] MIN_CHANNELS = 4'd6;
    localparam logic [3:0] MAX_CHANNELS_C = 4'(MAX_CHANNELS);
    localparam logic [6:0] WINDOW_FRAMES = 7'd100;
    localparam logic [10:0] WINDOW_ERR_MAX = 11'd1200;
    localparam logic [3:0] FRAME_ERR_MAX = 4'd15;
    localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;
    localparam logic [10:0] VALUE_LIMIT_RESET = 11'd1950;
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // configuration register indexes
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;

    // one completed channel word travelling from front to back
    typedef struct packed {
        logic [3:0]  ch;
        logic [15:0] raw;
        logic        last;
    } t_chan_item;

endpackage

// File: hw/rtl/scfd_if.sv
interface scfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface scfd_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic signed [11:0] channel_value;
    logic signed [11:0] ppm_value;
    logic               out_of_range;
    logic [3:0]         frame_errors;
    logic [10:0]        window_errors;
    logic               last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output ppm_value, output out_of_range, output frame_errors,
                    output window_errors, output last_channel, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input ppm_value, input out_of_range, input frame_errors,
                  input window_errors, input last_channel, output ready);
endinterface

interface scfd_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/scfd_front.sv
module scfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scfd_in_if.sink            i_in,
    input  logic [3:0]         i_channel_count,
    input  logic               i_q_space,
    output logic               o_push,
    output scfd_pkg::t_chan_item o_item
);
    import scfd_pkg::*;

    logic [4:0] r_pos, n_pos;
    logic       r_active, n_active;
    logic [7:0] r_low, n_low;
    logic [3:0] count_eff;
    logic [3:0] ch;
    logic       last;
    logic       accept;

    always_comb begin
        if (i_channel_count < MIN_CHANNELS) begin
            count_eff = MIN_CHANNELS;
        end else if (i_channel_count > MAX_CHANNELS_C) begin
            count_eff = MAX_CHANNELS_C;
        end else begin
            count_eff = i_channel_count;
        end
    end

    assign ch = r_pos[4:1];
    assign last = ({1'b0, ch} + 5'd1) == {1'b0, count_eff};
    assign i_in.ready = i_q_space;
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        n_pos = r_pos;
        n_active = r_active;
        n_low = r_low;
        o_push = 1'b0;
        if (accept) begin
            if (i_in.frame_start) begin
                n_active = 1'b1;
                n_pos = '0;
            end else if (r_active) begin
                if (ch >= count_eff) begin
                    n_active = 1'b0;
                end else if (!r_pos[0]) begin
                    n_low = i_in.rx_byte;
                    n_pos = r_pos + 5'd1;
                end else begin
                    o_push = 1'b1;
                    n_pos = r_pos + 5'd1;
                    if (last) begin
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    assign o_item.ch = ch;
    assign o_item.raw = {i_in.rx_byte, r_low};
    assign o_item.last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_active <= 1'b0;
            r_low <= '0;
        end else begin
            r_pos <= n_pos;
            r_active <= n_active;
            r_low <= n_low;
        end
    end

endmodule

// File: hw/rtl/scfd_queue.sv
`include "servo_channel_frame_decoder_unit_macros.svh"

module scfd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scfd_pkg::t_chan_item i_item,
    input  logic                 i_pop,
    output logic                 o_space,
    output logic                 o_valid,
    output scfd_pkg::t_chan_item o_item
);
    import scfd_pkg::*;

    t_chan_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_space = r_count != QUEUE_DEPTH;
    assign o_valid = r_count != 2'd0;
    assign o_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SCFD_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, r_count == QUEUE_DEPTH, !i_push)
    `SCFD_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, r_count == 2'd0, !i_pop)

endmodule

// File: hw/rtl/scfd_back.sv
`include "servo_channel_frame_decoder_unit_macros.svh"

module scfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [10:0]          i_value_limit,
    input  logic                 i_q_valid,
    input  scfd_pkg::t_chan_item i_item,
    output logic                 o_pop,
    scfd_out_if.source           o_out
);
    import scfd_pkg::*;

    logic signed [11:0] r_held [MAX_CHANNELS];
    logic [3:0]         r_frame_err;
    logic [10:0]        r_win_err;
    logic [6:0]         r_win_frames;

    logic               r_out_valid;
    logic [3:0]         r_out_ch;
    logic signed [11:0] r_out_value;
    logic signed [11:0] r_out_ppm;
    logic               r_out_oor;
    logic [3:0]         r_out_fe;
    logic [10:0]        r_out_we;
    logic               r_out_last;

    logic signed [16:0] v17;
    logic signed [16:0] lim17;
    logic               reject;
    logic signed [11:0] value;
    logic signed [11:0] ppm;
    logic [3:0]         fe_base;
    logic [3:0]         fe_next;
    logic [10:0]        we_next;
    logic [6:0]         wf_inc;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    assign v17 = signed'({i_item.raw[15], i_item.raw});
    assign lim17 = signed'({6'd0, i_value_limit});
    assign reject = (v17 > lim17) || (v17 < -lim17);
    assign value = reject ? r_held[i_item.ch] : signed'(i_item.raw[11:0]);
    assign ppm = value - (value >>> 1);

    // a new frame always restarts at channel zero
    assign fe_base = (i_item.ch == 4'd0) ? 4'd0 : r_frame_err;
    assign fe_next = (reject && fe_base != FRAME_ERR_MAX) ? fe_base + 4'd1 : fe_base;
    assign we_next = (reject && r_win_err != WINDOW_ERR_MAX) ? r_win_err + 11'd1 : r_win_err;
    assign wf_inc = r_win_frames + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_held[i] <= '0;
            end
            r_frame_err <= '0;
            r_win_err <= '0;
            r_win_frames <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (!reject) begin
                    r_held[i_item.ch] <= value;
                end
                r_frame_err <= fe_next;
                if (i_item.last && wf_inc == WINDOW_FRAMES) begin
                    r_win_frames <= '0;
                    r_win_err <= '0;
                end else begin
                    if (i_item.last) begin
                        r_win_frames <= wf_inc;
                    end
                    r_win_err <= we_next;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_ch <= i_item.ch;
            r_out_value <= value;
            r_out_ppm <= ppm;
            r_out_oor <= reject;
            r_out_fe <= fe_next;
            r_out_we <= we_next;
            r_out_last <= i_item.last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.channel_index = r_out_ch;
    assign o_out.channel_value = r_out_value;
    assign o_out.ppm_value = r_out_ppm;
    assign o_out.out_of_range = r_out_oor;
    assign o_out.frame_errors = r_out_fe;
    assign o_out.window_errors = r_out_we;
    assign o_out.last_channel = r_out_last;

    `SCFD_ASSERT_IMP(a_oor_counted, i_clk, i_rst_n, r_out_valid && r_out_oor, r_out_fe != 4'd0 && r_out_we != 11'd0)
    `SCFD_ASSERT_IMP(a_win_err_sat, i_clk, i_rst_n, 1'b1, r_win_err <= WINDOW_ERR_MAX)
    `SCFD_ASSERT_NXT(a_window_wrap, i_clk, i_rst_n, o_pop && i_item.last && wf_inc == WINDOW_FRAMES, r_win_frames == 7'd0 && r_win_err == 11'd0)

endmodule

// File: hw/rtl/servo_channel_frame_decoder_unit.sv
// Servo channel frame decoder.
// i_in takes one received byte per transfer with a frame_start flag; a byte
// with frame_start set is the frame header and opens a new frame. Each later
// pair of bytes (low byte first) is one signed 16-bit channel value, and each
// completed pair yields one transfer on o_out with the value (held if rejected),
// the PPM value, the reject flag, the error counts and a last-channel flag.
// i_cfg writes channel_count (index 0) and value_limit (index 1); it is always
// ready; the user must write it only while the block is idle (not enforced).
// o_out.valid rises once the high byte of its channel has been pushed into the
// front-to-back queue and popped from it into the back-end output register.
// Throughput: one byte per cycle while the queue has space, set by the range
// check and held-value update in the back end.
// A two-entry queue between the byte parser and the back end lets the parser
// keep taking bytes while a result waits on o_out; when the receiver stalls,
// i_in.ready drops once the queue is full and the output register holds.
// Reset (synchronous, active low) clears the frame state, held values, error
// and frame counters and restores channel_count 8 and value_limit 1950.
module servo_channel_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfd_in_if.sink     i_in,
    scfd_out_if.source  o_out,
    scfd_cfg_if.sink    i_cfg
);
    import scfd_pkg::*;

    logic [3:0]  r_channel_count;
    logic [10:0] r_value_limit;
    logic        q_space;
    logic        q_valid;
    logic        push;
    logic        pop;
    t_chan_item  push_item;
    t_chan_item  head_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RESET;
            r_value_limit <= VALUE_LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[3:0];
                REG_VALUE_LIMIT:   r_value_limit <= i_cfg.data;
                default:           r_value_limit <= r_value_limit;
            endcase
        end
    end

    scfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_channel_count (r_channel_count),
        .i_q_space       (q_space),
        .o_push          (push),
        .o_item          (push_item)
    );

    scfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    scfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_limit (r_value_limit),
        .i_q_valid     (q_valid),
        .i_item        (head_item),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule
